/* rtl/nearest_palette_color_search_macros.svh */
// ----------------------------------------------------------------------------
// Nearest palette colour search - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// Same-cycle implication
`define NPCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npcs: same-cycle check failed");

// Next-cycle implication
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npcs: next-cycle check failed");

`endif

/* rtl/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the nearest palette colour search.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int COLOR_W = 8;
    localparam int ENTRY_W = 3 * COLOR_W;
    localparam int SQ_W    = 2 * COLOR_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int INDEX_W = 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Tag travelling with each entry through the distance pipeline
    typedef struct packed {
        logic               vld;
        logic               last;
        logic [INDEX_W-1:0] idx;
    } npcs_tag_t;

endpackage

/* rtl/nearest_palette_color_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with a sequential nearest-colour (squared RGB) search.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd selects a palette write or a query;
// entry_index, red, green, blue carry the payload. A write beat gives no
// result; writes at or beyond PALETTE_DEPTH are dropped. A query scans
// entries 1 to PALETTE_DEPTH-2, one entry per cycle through one RAM read
// port and one distance pipeline, and returns the lowest index of minimum
// squared distance on the output channel (out_valid/out_ready).
// in_ready stays low from the acceptance of a query until its result is
// loaded into the output register, so no new beat is taken while a query
// is in progress. Writes and a new query may be accepted while a
// result waits; a query that finishes before the previous result is taken
// holds in_ready low until the output register frees.
// Reset clears the palette at once through per-entry valid bits: an entry
// never written reads as black. Output and control state are cleared.
// ----------------------------------------------------------------------------
module nearest_palette_color_search #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [npcs_pkg::INDEX_W-1:0]   entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]   red,
    input  logic [npcs_pkg::COLOR_W-1:0]   green,
    input  logic [npcs_pkg::COLOR_W-1:0]   blue,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [npcs_pkg::INDEX_W-1:0]   nearest_index
);

    localparam int AW   = $clog2(PALETTE_DEPTH);
    localparam int LAST = PALETTE_DEPTH - 2;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_t;

    state_t                          state_reg;
    logic [AW-1:0]                   addr_reg;
    logic                            issue_reg;
    logic [PALETTE_DEPTH-1:0]        pal_valid_reg;
    logic                            present_reg;
    npcs_pkg::npcs_tag_t             tag_rd_reg;
    logic [npcs_pkg::COLOR_W-1:0]    q_red_reg, q_green_reg, q_blue_reg;
    logic [npcs_pkg::DIST_W-1:0]     best_dist_reg;
    logic [npcs_pkg::INDEX_W-1:0]    best_idx_reg;
    logic                            out_valid_reg;
    logic [npcs_pkg::INDEX_W-1:0]    nearest_index_reg;

    logic                            in_acc;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic                            rd_en;
    logic                            is_last;
    npcs_pkg::npcs_tag_t             tag_rd_next;
    logic [npcs_pkg::ENTRY_W-1:0]    rd_data;
    logic [npcs_pkg::ENTRY_W-1:0]    entry_eff;
    npcs_pkg::npcs_tag_t             tag_d;
    logic [npcs_pkg::DIST_W-1:0]     dist_d;
    logic                            better;
    logic                            out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign wr_en    = in_acc && (cmd == npcs_pkg::CMD_WRITE)
                   && ({1'b0, entry_index} < 9'(PALETTE_DEPTH));
    assign wr_addr  = entry_index[AW-1:0];
    assign rd_en    = (state_reg == S_SCAN) && issue_reg;
    assign is_last  = (addr_reg == AW'(LAST));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        tag_rd_next.vld  = rd_en;
        tag_rd_next.last = is_last;
        tag_rd_next.idx  = npcs_pkg::INDEX_W'(addr_reg);
    end

    npcs_ram #(
        .WIDTH (npcs_pkg::ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({red, green, blue}),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // unwritten entries read as black
    assign entry_eff = present_reg ? rd_data : '0;

    npcs_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag_rd_reg),
        .entry    (entry_eff),
        .q_red    (q_red_reg),
        .q_green  (q_green_reg),
        .q_blue   (q_blue_reg),
        .tag_out  (tag_d),
        .dist_sum (dist_d)
    );

    assign better = tag_d.vld && (dist_d < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            addr_reg          <= '0;
            issue_reg         <= 1'b0;
            pal_valid_reg     <= '0;
            present_reg       <= 1'b0;
            tag_rd_reg        <= '0;
            q_red_reg         <= '0;
            q_green_reg       <= '0;
            q_blue_reg        <= '0;
            best_dist_reg     <= '1;
            best_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
            nearest_index_reg <= '0;
        end
        else
        begin
            tag_rd_reg  <= tag_rd_next;
            present_reg <= pal_valid_reg[addr_reg];

            if (wr_en)
            begin
                pal_valid_reg[wr_addr] <= 1'b1;
            end

            if ((state_reg == S_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (better)
            begin
                best_dist_reg <= dist_d;
                best_idx_reg  <= tag_d.idx;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (cmd == npcs_pkg::CMD_QUERY))
                    begin
                        q_red_reg     <= red;
                        q_green_reg   <= green;
                        q_blue_reg    <= blue;
                        addr_reg      <= AW'(1);
                        issue_reg     <= 1'b1;
                        best_dist_reg <= '1;
                        best_idx_reg  <= '0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (issue_reg)
                    begin
                        if (is_last)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + AW'(1);
                        end
                    end
                    if (tag_d.vld && tag_d.last)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        nearest_index_reg <= best_idx_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = nearest_index_reg;

endmodule

/* rtl/npcs_ram.sv */
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/npcs_dist.sv */
// ----------------------------------------------------------------------------
// npcs_dist
// Three-stage squared RGB distance pipeline: abs difference, square, sum.
// ----------------------------------------------------------------------------
module npcs_dist (
    input  logic                               clk,
    input  logic                               rst_n,
    input  npcs_pkg::npcs_tag_t                tag_in,
    input  logic [npcs_pkg::ENTRY_W-1:0]       entry,
    input  logic [npcs_pkg::COLOR_W-1:0]       q_red,
    input  logic [npcs_pkg::COLOR_W-1:0]       q_green,
    input  logic [npcs_pkg::COLOR_W-1:0]       q_blue,
    output npcs_pkg::npcs_tag_t                tag_out,
    output logic [npcs_pkg::DIST_W-1:0]        dist_sum
);

    npcs_pkg::npcs_tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic [npcs_pkg::COLOR_W-1:0]     dr_reg, dg_reg, db_reg;
    logic [npcs_pkg::SQ_W-1:0]        sr_reg, sg_reg, sb_reg;
    logic [npcs_pkg::DIST_W-1:0]      sum_reg;
    logic [npcs_pkg::COLOR_W-1:0]     e_red, e_green, e_blue;
    logic [npcs_pkg::COLOR_W-1:0]     dr_next, dg_next, db_next;

    assign e_red   = entry[3*npcs_pkg::COLOR_W-1:2*npcs_pkg::COLOR_W];
    assign e_green = entry[2*npcs_pkg::COLOR_W-1:npcs_pkg::COLOR_W];
    assign e_blue  = entry[npcs_pkg::COLOR_W-1:0];

    always_comb
    begin
        dr_next = (q_red   >= e_red)   ? q_red   - e_red   : e_red   - q_red;
        dg_next = (q_green >= e_green) ? q_green - e_green : e_green - q_green;
        db_next = (q_blue  >= e_blue)  ? q_blue  - e_blue  : e_blue  - q_blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg  <= dr_next;
        dg_reg  <= dg_next;
        db_reg  <= db_next;
        sr_reg  <= npcs_pkg::SQ_W'(dr_reg) * npcs_pkg::SQ_W'(dr_reg);
        sg_reg  <= npcs_pkg::SQ_W'(dg_reg) * npcs_pkg::SQ_W'(dg_reg);
        sb_reg  <= npcs_pkg::SQ_W'(db_reg) * npcs_pkg::SQ_W'(db_reg);
        sum_reg <= npcs_pkg::DIST_W'(sr_reg) + npcs_pkg::DIST_W'(sg_reg)
                 + npcs_pkg::DIST_W'(sb_reg);
    end

    assign tag_out  = tag3_reg;
    assign dist_sum = sum_reg;

endmodule

/* rtl/npcs_checker.sv */
// ----------------------------------------------------------------------------
// npcs_checker
// Port-level checks of the nearest palette colour search, bound to the top.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_search_macros.svh"

module npcs_checker #(
    parameter int PALETTE_DEPTH = 256
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           cmd,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [npcs_pkg::INDEX_W-1:0]   nearest_index
);

    logic query_beat;
    logic write_beat;

    assign query_beat = in_valid && in_ready && (cmd == npcs_pkg::CMD_QUERY);
    assign write_beat = in_valid && in_ready && (cmd == npcs_pkg::CMD_WRITE);

    // result beat held while stalled
    `NPCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(nearest_index))

    // reserved entries never returned
    `NPCS_ASSERT_IMPLY(a_idx_range, clk, rst_n, out_valid,
        (nearest_index != '0) && ({1'b0, nearest_index} < 9'(PALETTE_DEPTH - 1)))

    // a query beat starts a scan, so the next beat must wait
    `NPCS_ASSERT_NEXT(a_query_busy, clk, rst_n, query_beat, !in_ready)

    // a write beat never produces a result
    `NPCS_ASSERT_NEXT(a_write_silent, clk, rst_n, write_beat && !out_valid, !out_valid)

endmodule

bind nearest_palette_color_search npcs_checker #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
) u_npcs_checker (.*);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - nearest palette colour search testbench
// Fills the palette with write beats and checks the index returned for every
// query against a shadow palette searched in the testbench. Directed beats
// cover reset contents, the reserved entries, ties and the channel extremes;
// the random part mixes writes from a small tone set (to force ties) with
// queries near stored colours, under sender and receiver idling, one long
// receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PALETTE_DEPTH   = 256;
    localparam int RANDOM_PER_MODE = 540;
    localparam int BURST_QUERIES   = 8;
    localparam int HOLD_CYCLES     = 3000;
    localparam int LIMIT_CYCLES    = 4000000;

    class palette_shadow;
        bit [npcs_pkg::ENTRY_W-1:0] palette [PALETTE_DEPTH];
        bit [npcs_pkg::INDEX_W-1:0] expected_index_q [$];
        int mismatches;
        int writes_noted;
        int queries_noted;
        int results_checked;

        function new();
            foreach (palette[i])
                palette[i] = '0;
            mismatches      = 0;
            writes_noted    = 0;
            queries_noted   = 0;
            results_checked = 0;
        endfunction

        function bit [npcs_pkg::INDEX_W-1:0] nearest_entry(bit [7:0] r, bit [7:0] g,
                                                           bit [7:0] b);
            int dr;
            int dg;
            int db;
            int d;
            int best_d;
            bit [npcs_pkg::INDEX_W-1:0] best_i;
            best_d = 32'h7FFF_FFFF;
            best_i = '0;
            for (int i = 1; i < PALETTE_DEPTH - 1; i++)
            begin
                dr = int'(r) - int'(palette[i][23:16]);
                dg = int'(g) - int'(palette[i][15:8]);
                db = int'(b) - int'(palette[i][7:0]);
                d  = dr * dr + dg * dg + db * db;
                if (d < best_d)
                begin
                    best_d = d;
                    best_i = npcs_pkg::INDEX_W'(i);
                end
            end
            return best_i;
        endfunction

        function void note_beat(logic c, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
            if (c == npcs_pkg::CMD_WRITE)
            begin
                if (int'(idx) < PALETTE_DEPTH)
                    palette[idx] = {r, g, b};
                writes_noted++;
            end
            else
            begin
                expected_index_q.push_back(nearest_entry(r, g, b));
                queries_noted++;
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_index(logic [npcs_pkg::INDEX_W-1:0] got);
            bit [npcs_pkg::INDEX_W-1:0] want;
            results_checked++;
            if (expected_index_q.size() == 0)
                report($sformatf("result %0d with no query outstanding", got));
            else
            begin
                want = expected_index_q.pop_front();
                if (got !== want)
                    report($sformatf("nearest_index %0d, expected %0d", got, want));
            end
        endtask

        function int pending();
            return expected_index_q.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          cmd;
    logic [npcs_pkg::INDEX_W-1:0]  entry_index;
    logic [npcs_pkg::COLOR_W-1:0]  red;
    logic [npcs_pkg::COLOR_W-1:0]  green;
    logic [npcs_pkg::COLOR_W-1:0]  blue;
    logic                          out_valid;
    logic                          out_ready;
    logic [npcs_pkg::INDEX_W-1:0]  nearest_index;

    palette_shadow              shadow;
    int                         tx_idle_pct;
    int                         rx_idle_pct;
    bit                         hold_request;
    int                         hold_left;
    int                         beats_sent;
    bit [npcs_pkg::ENTRY_W-1:0] tone [8];

    nearest_palette_color_search #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .nearest_index (nearest_index)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    task automatic send_beat(logic c, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.note_beat(c, idx, r, g, b);
        beats_sent++;
    endtask

    task automatic write_entry(logic [7:0] idx, logic [23:0] rgb);
        send_beat(npcs_pkg::CMD_WRITE, idx, rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    task automatic query_colour(logic [23:0] rgb);
        send_beat(npcs_pkg::CMD_QUERY, 8'($urandom), rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] jitter(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 10)) - 5;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic send_random_beat();
        int          pick;
        int          slot;
        logic [7:0]  idx;
        logic [23:0] rgb;
        pick = $urandom_range(0, 99);
        if (pick < 58)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                idx = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            else if (pick < 40)
                idx = 8'($urandom_range(1, 15));
            else
                idx = 8'($urandom);
            if ($urandom_range(0, 99) < 40)
                rgb = tone[$urandom_range(0, 7)];
            else
                rgb = 24'($urandom);
            write_entry(idx, rgb);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(1, PALETTE_DEPTH - 2);
            if (pick < 30)
                rgb = shadow.palette[slot];
            else if (pick < 60)
            begin
                rgb = shadow.palette[slot];
                rgb = {jitter(rgb[23:16]), jitter(rgb[15:8]), jitter(rgb[7:0])};
            end
            else if (pick < 70)
                rgb = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            else
                rgb = 24'($urandom);
            query_colour(rgb);
        end
    endtask

    // receiver: random idling, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            shadow.check_index(nearest_index);

    initial
    begin
        #(8 * LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        shadow       = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = npcs_pkg::CMD_WRITE;
        entry_index  = '0;
        red          = '0;
        green        = '0;
        blue         = '0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b0;
        beats_sent   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset palette, reserved entries, ties, extremes
        query_colour(24'h000000);
        query_colour(24'hFFFFFF);
        write_entry(8'd0, 24'h0A141E);
        write_entry(8'd255, 24'hC86432);
        query_colour(24'h0A141E);
        query_colour(24'hC86432);
        write_entry(8'd254, 24'hFFFFFF);
        query_colour(24'hFFFFFF);
        write_entry(8'd1, 24'hFFFFFF);
        query_colour(24'hFFFFFF);
        write_entry(8'd128, 24'h8000FF);
        query_colour(24'h7F01FE);
        query_colour(24'h000000);
        write_entry(8'd2, 24'h000001);
        write_entry(8'd3, 24'h000001);
        query_colour(24'h000000);
        write_entry(8'd100, 24'hFF0000);
        query_colour(24'hFF0000);
        write_entry(8'd0, 24'hFF0000);
        write_entry(8'd255, 24'hF00000);
        query_colour(24'hF00000);
        drain_wait();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 75;
                end
                1:
                begin
                    tx_idle_pct = 75;
                    rx_idle_pct = 7;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            tone[0] = 24'h000000;
            tone[1] = 24'hFFFFFF;
            for (int t = 2; t < 8; t++)
                tone[t] = 24'($urandom);
            if (mode == 2)
            begin
                // long output stall with queries still offered
                hold_request = 1'b1;
                for (int q = 0; q < BURST_QUERIES; q++)
                    query_colour(24'($urandom));
            end
            for (int n = 0; n < RANDOM_PER_MODE; n++)
                send_random_beat();
            drain_wait();
        end

        repeat (PALETTE_DEPTH + 16) @(posedge clk);

        $display("run covered %0d beats: %0d palette writes, %0d queries",
                 beats_sent, shadow.writes_noted, shadow.queries_noted);
        $display("%0d results checked, %0d mismatches", shadow.results_checked,
                 shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/npcs_pkg.sv
rtl/npcs_ram.sv
rtl/npcs_dist.sv
rtl/nearest_palette_color_search.sv
rtl/npcs_checker.sv
sim/tb_top.sv
